FILE: hdl/hvsc_pkg.sv
`timescale 1ns / 1ps
package hvsc_pkg;

    // saturation pressure polynomial, scaled by 1e11: A*T^2 - B*T + C
    localparam logic [15:0]        Q_A = 16'd49569;
    localparam logic [25:0]        Q_B = 26'd54750000;
    localparam logic signed [43:0] Q_C = 44'sd143740000000;

    // atmospheric pressure scaled by 1e15, and 0.622 scaled to 0.001 g/kg
    localparam logic [56:0] D_K = 57'd101325000000000000;
    localparam logic [19:0] N_K = 20'd622000;

    localparam logic [15:0] RATIO_MAX = 16'hFFFF;

    // floor(x/13) and floor(x/11) for x < 2^20 as (x*R) >> RECIP_SH
    localparam logic [20:0] RECIP_13 = 21'd1290556;
    localparam logic [20:0] RECIP_11 = 21'd1525202;
    localparam int          RECIP_SH = 24;

    localparam int BAND_HIGH_MIN = 6000;
    localparam int BAND_MID_MIN  = 3000;
    localparam int HIGH_CLAMP    = 5800;
    localparam int MID_LO_CLAMP  = 2800;
    localparam int MID_HI_CLAMP  = 6200;
    localparam int STEP_MIN      = 260;
    localparam int ERR_DEAD      = 250;
    localparam int VALVE_MAX     = 10000;
    localparam int VALVE_FLOOR   = 270;
    localparam int VALVE_NEG     = 10;

    localparam logic [15:0] TARGET_RESET = 16'd10000;

    typedef enum logic [1:0] {
        BAND_LOW,
        BAND_MID,
        BAND_HIGH
    } t_band;

    typedef struct packed {
        logic [15:0] ratio;
        logic        sat;
        logic [13:0] fb;
    } t_front_res;

endpackage

FILE: hdl/hvsc_if.sv
`timescale 1ns / 1ps
interface hvsc_in_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] outlet_temp;
    logic        [13:0] outlet_rh;
    logic        [13:0] valve_feedback;

    modport source (output valid, output outlet_temp, output outlet_rh,
                    output valve_feedback, input ready);
    modport sink (input valid, input outlet_temp, input outlet_rh,
                  input valve_feedback, output ready);
endinterface

interface hvsc_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] valve_command;
    logic [15:0] humidity_ratio;
    logic        ratio_saturated;

    modport source (output valid, output valve_command, output humidity_ratio,
                    output ratio_saturated, input ready);
    modport sink (input valid, input valve_command, input humidity_ratio,
                  input ratio_saturated, output ready);
endinterface

interface hvsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/hvsc_front.sv
`timescale 1ns / 1ps
module hvsc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hvsc_in_if.sink               i_sample,
    output logic                  o_res_valid,
    output hvsc_pkg::t_front_res  o_res,
    input  logic                  i_res_ready
);

    localparam int NDIV = 16;
    localparam int NPRE = 8;
    localparam int LAST = NPRE + NDIV - 1;
    localparam int NW   = 76;

    logic en;

    logic              r_vld [0:LAST];
    logic [13:0]       r_fb  [0:LAST];

    logic [26:0]        r_tsq;
    logic signed [39:0] r_lin0;
    logic signed [39:0] r_lin1;
    logic [13:0]        r_rh0;
    logic [13:0]        r_rh1;
    logic [13:0]        r_rh2;
    logic [41:0]        r_quad;
    logic [41:0]        r_q;
    logic [34:0]        r_pph;
    logic [34:0]        r_ppl;
    logic [55:0]        r_a;
    logic [47:0]        r_nh;
    logic [47:0]        r_nl;
    logic [56:0]        r_d5;
    logic [56:0]        r_d6;
    logic [56:0]        r_d7;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_rem7;
    logic               r_sat7;

    logic [NW-1:0] r_rem [0:NDIV-1];
    logic [56:0]   r_dd  [0:NDIV-1];
    logic [15:0]   r_quo [0:NDIV-1];
    logic          r_sat [0:NDIV-1];

    logic [NW-1:0] c_rin  [0:NDIV-1];
    logic [56:0]   c_din  [0:NDIV-1];
    logic [15:0]   c_qin  [0:NDIV-1];
    logic          c_sin  [0:NDIV-1];
    logic [NW-1:0] c_dsh  [0:NDIV-1];
    logic          c_ge   [0:NDIV-1];
    logic [15:0]   c_qout [0:NDIV-1];

    logic signed [27:0] c_tsq_full;
    logic signed [40:0] c_lin_full;
    logic [42:0]        c_quad_full;
    logic signed [43:0] c_q_sum;

    // advance the whole pipe unless the last stage is blocked
    assign en = !r_vld[LAST] || i_res_ready;
    assign i_sample.ready = en;

    assign c_tsq_full  = i_sample.outlet_temp * i_sample.outlet_temp;
    assign c_lin_full  = $signed({1'b0, hvsc_pkg::Q_B}) * i_sample.outlet_temp;
    assign c_quad_full = hvsc_pkg::Q_A * r_tsq;
    assign c_q_sum     = $signed({2'b0, r_quad}) - $signed({{4{r_lin1[39]}}, r_lin1})
                         + hvsc_pkg::Q_C;

    always_comb begin
        c_rin[0] = r_rem7;
        c_din[0] = r_d7;
        c_qin[0] = '0;
        c_sin[0] = r_sat7;
        for (int j = 1; j < NDIV; j++) begin
            c_rin[j] = r_rem[j-1];
            c_din[j] = r_dd[j-1];
            c_qin[j] = r_quo[j-1];
            c_sin[j] = r_sat[j-1];
        end
        for (int j = 0; j < NDIV; j++) begin
            c_dsh[j] = {{(NW-57){1'b0}}, c_din[j]} << (NDIV - 1 - j);
            c_ge[j]  = c_rin[j] >= c_dsh[j];
            c_qout[j] = c_qin[j];
            c_qout[j][NDIV-1-j] = c_ge[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_sample.valid;
            for (int s = 1; s <= LAST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fb[0] <= i_sample.valve_feedback;
            for (int s = 1; s <= LAST; s++) begin
                r_fb[s] <= r_fb[s-1];
            end
            // temperature square and linear term
            r_tsq  <= c_tsq_full[26:0];
            r_lin0 <= c_lin_full[39:0];
            r_rh0  <= i_sample.outlet_rh;
            // quadratic term
            r_quad <= c_quad_full[41:0];
            r_lin1 <= r_lin0;
            r_rh1  <= r_rh0;
            // saturation pressure
            r_q   <= c_q_sum[41:0];
            r_rh2 <= r_rh1;
            // vapor pressure in two partial products
            r_pph <= r_rh2 * r_q[41:21];
            r_ppl <= r_rh2 * r_q[20:0];
            r_a   <= {r_pph, 21'b0} + {21'b0, r_ppl};
            // numerator partials and denominator
            r_nh <= hvsc_pkg::N_K * r_a[55:28];
            r_nl <= hvsc_pkg::N_K * r_a[27:0];
            r_d5 <= hvsc_pkg::D_K - {1'b0, r_a};
            r_n  <= {r_nh, 28'b0} + {28'b0, r_nl};
            r_d6 <= r_d5;
            // overflow check ahead of the 16 quotient bits
            r_sat7 <= r_n >= {3'b0, r_d6, 16'b0};
            r_rem7 <= r_n;
            r_d7   <= r_d6;
            for (int j = 0; j < NDIV; j++) begin
                r_rem[j] <= c_ge[j] ? c_rin[j] - c_dsh[j] : c_rin[j];
                r_dd[j]  <= c_din[j];
                r_quo[j] <= c_qout[j];
                r_sat[j] <= c_sin[j];
            end
        end
    end

    assign o_res_valid = r_vld[LAST];
    assign o_res.ratio = r_sat[NDIV-1] ? hvsc_pkg::RATIO_MAX : r_quo[NDIV-1];
    assign o_res.sat   = r_sat[NDIV-1];
    assign o_res.fb    = r_fb[LAST];

endmodule

FILE: hdl/hvsc_queue.sv
`timescale 1ns / 1ps
module hvsc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    input  hvsc_pkg::t_front_res i_push_data,
    output logic                 o_push_ready,
    output logic                 o_pop_valid,
    output hvsc_pkg::t_front_res o_pop_data,
    input  logic                 i_pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hvsc_pkg::t_front_res r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = r_count != CW'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: hdl/hvsc_back.sv
`timescale 1ns / 1ps
module hvsc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  hvsc_pkg::t_front_res i_res,
    output logic                 o_res_ready,
    input  logic [15:0]          i_target,
    hvsc_out_if.source           o_result
);

    localparam logic signed [18:0] S_HIGH_MIN = 19'(hvsc_pkg::BAND_HIGH_MIN);
    localparam logic signed [18:0] S_MID_MIN  = 19'(hvsc_pkg::BAND_MID_MIN);
    localparam logic signed [18:0] S_HIGH_CL  = 19'(hvsc_pkg::HIGH_CLAMP);
    localparam logic signed [18:0] S_MID_LO   = 19'(hvsc_pkg::MID_LO_CLAMP);
    localparam logic signed [18:0] S_MID_HI   = 19'(hvsc_pkg::MID_HI_CLAMP);
    localparam logic signed [18:0] S_STEP     = 19'(hvsc_pkg::STEP_MIN);
    localparam logic signed [18:0] S_VMAX     = 19'(hvsc_pkg::VALVE_MAX);
    localparam logic signed [18:0] S_VFLOOR   = 19'(hvsc_pkg::VALVE_FLOOR);
    localparam logic signed [18:0] S_VNEG     = 19'(hvsc_pkg::VALVE_NEG);
    localparam logic signed [16:0] S_DEAD     = 17'(hvsc_pkg::ERR_DEAD);

    logic en_out;
    logic en_b1;

    logic signed [16:0] c_err;
    logic [15:0]        c_mag;
    hvsc_pkg::t_band    c_band;
    logic [19:0]        c_mk;
    logic [20:0]        c_recip;
    logic [40:0]        c_prod;

    logic               r_b1_vld;
    logic [15:0]        r_y;
    logic               r_neg;
    hvsc_pkg::t_band    r_band;
    logic [13:0]        r_fb;
    logic [15:0]        r_ratio;
    logic               r_sat;
    logic               r_elo;
    logic               r_ehi;

    logic signed [18:0] c_f;
    logic signed [18:0] c_v0;
    logic signed [18:0] c_v1;
    logic signed [18:0] c_dv;
    logic signed [18:0] c_v2;
    logic signed [18:0] c_v3;

    logic        r_out_vld;
    logic [13:0] r_cmd;
    logic [15:0] r_ratio_o;
    logic        r_sat_o;

    assign en_out      = !r_out_vld || o_result.ready;
    assign en_b1       = !r_b1_vld || en_out;
    assign o_res_ready = en_b1;

    // error magnitude times band gain, divided through a reciprocal
    always_comb begin
        c_err = $signed({1'b0, i_target}) - $signed({1'b0, i_res.ratio});
        c_mag = c_err[16] ? 16'(-c_err) : c_err[15:0];
        if (i_res.fb >= 14'(hvsc_pkg::BAND_HIGH_MIN)) begin
            c_band = hvsc_pkg::BAND_HIGH;
        end else if (i_res.fb >= 14'(hvsc_pkg::BAND_MID_MIN)) begin
            c_band = hvsc_pkg::BAND_MID;
        end else begin
            c_band = hvsc_pkg::BAND_LOW;
        end
        case (c_band)
            hvsc_pkg::BAND_HIGH: begin
                c_mk    = (20'(c_mag) << 3) + (20'(c_mag) << 1);
                c_recip = hvsc_pkg::RECIP_13;
            end
            hvsc_pkg::BAND_MID: begin
                c_mk    = (20'(c_mag) << 2) + (20'(c_mag) << 1);
                c_recip = hvsc_pkg::RECIP_13;
            end
            default: begin
                c_mk    = (20'(c_mag) << 2) + 20'(c_mag);
                c_recip = hvsc_pkg::RECIP_11;
            end
        endcase
        c_prod = c_mk * c_recip;
    end

    always_comb begin
        c_f  = $signed({5'b0, r_fb});
        c_v0 = r_neg ? c_f + $signed({3'b0, r_y}) : c_f - $signed({3'b0, r_y});
        c_v1 = c_v0;
        case (r_band)
            hvsc_pkg::BAND_HIGH: begin
                if (c_v0 <= S_HIGH_MIN) begin
                    c_v1 = S_HIGH_CL;
                end
            end
            hvsc_pkg::BAND_MID: begin
                if (c_v0 <= S_MID_MIN) begin
                    c_v1 = S_MID_LO;
                end else if (c_v0 >= S_HIGH_MIN) begin
                    c_v1 = S_MID_HI;
                end
            end
            default: begin
                c_v1 = c_v0;
            end
        endcase
        // enforce a minimum step when the error is large
        c_dv = c_v1 - c_f;
        c_v2 = c_v1;
        if (r_elo && c_dv > 19'sd0 && c_dv < S_STEP) begin
            c_v2 = c_f + S_STEP;
        end else if (r_ehi && c_dv < 19'sd0 && c_dv > -S_STEP) begin
            c_v2 = c_f - S_STEP;
        end
        if (c_v2 > S_VMAX) begin
            c_v3 = S_VMAX;
        end else if (c_v2 < S_VFLOOR && c_v2 > 19'sd0) begin
            c_v3 = S_VFLOOR;
        end else if (c_v2 < 19'sd0) begin
            c_v3 = S_VNEG;
        end else begin
            c_v3 = c_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en_b1) begin
                r_b1_vld <= i_res_valid;
            end
            if (en_out) begin
                r_out_vld <= r_b1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b1) begin
            r_y     <= c_prod[39:hvsc_pkg::RECIP_SH];
            r_neg   <= c_err[16];
            r_band  <= c_band;
            r_fb    <= i_res.fb;
            r_ratio <= i_res.ratio;
            r_sat   <= i_res.sat;
            r_elo   <= c_err < -S_DEAD;
            r_ehi   <= c_err > S_DEAD;
        end
        if (en_out) begin
            r_cmd     <= c_v3[13:0];
            r_ratio_o <= r_ratio;
            r_sat_o   <= r_sat;
        end
    end

    assign o_result.valid           = r_out_vld;
    assign o_result.valve_command   = r_cmd;
    assign o_result.humidity_ratio  = r_ratio_o;
    assign o_result.ratio_saturated = r_sat_o;

endmodule

FILE: hdl/humidity_valve_step_controller.sv
`timescale 1ns / 1ps
// Humidity ratio valve step controller. Takes one sample (outlet temperature,
// outlet humidity, valve feedback) per cycle when not stalled and returns one
// result per sample in order: the new valve command, the outlet humidity ratio
// in 0.001 g/kg and a flag set when the ratio saturated at 65535. Sustained
// rate is one item per clock unless the result port applies back-pressure. A
// sample passes the fully pipelined ratio datapath (eight multiply/add stages
// plus a restoring divider that resolves one quotient bit per stage), the queue,
// and the valve law and output registers. The target ratio resets to 10000 and
// may be written whenever no item is in flight; the config port is always ready.
module humidity_valve_step_controller #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hvsc_in_if.sink    i_sample,
    hvsc_cfg_if.sink   i_cfg,
    hvsc_out_if.source o_result
);

    logic [15:0]          r_target;
    logic                 front_valid;
    hvsc_pkg::t_front_res front_res;
    logic                 front_ready;
    logic                 back_valid;
    hvsc_pkg::t_front_res back_res;
    logic                 back_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= hvsc_pkg::TARGET_RESET;
        end else if (i_cfg.valid) begin
            r_target <= i_cfg.data;
        end
    end

    hvsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .o_res_valid (front_valid),
        .o_res       (front_res),
        .i_res_ready (front_ready)
    );

    hvsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_data  (front_res),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_data   (back_res),
        .i_pop_ready  (back_ready)
    );

    hvsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (back_valid),
        .i_res       (back_res),
        .o_res_ready (back_ready),
        .i_target    (r_target),
        .o_result    (o_result)
    );

endmodule

FILE: hdl/hvsc_checker.sv
`timescale 1ns / 1ps
module hvsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [13:0] i_cmd,
    input logic [15:0] i_ratio,
    input logic        i_sat
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_cmd) && $stable(i_ratio)
                                && $stable(i_sat))
        else $error("result changed while stalled");

    a_cmd_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_cmd <= 14'(hvsc_pkg::VALVE_MAX))
        else $error("valve command above full open");

    a_cmd_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_cmd == 14'd0 || i_cmd >= 14'(hvsc_pkg::VALVE_FLOOR)
                     || i_cmd == 14'(hvsc_pkg::VALVE_NEG)))
        else $error("valve command inside the floor band");

    a_sat_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_sat |-> i_ratio == hvsc_pkg::RATIO_MAX)
        else $error("saturated ratio not at its maximum");

endmodule

bind humidity_valve_step_controller hvsc_checker u_hvsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_cmd   (o_result.valve_command),
    .i_ratio (o_result.humidity_ratio),
    .i_sat   (o_result.ratio_saturated)
);
